// ===== design/assert_macros.svh =====
// Assertion macros shared by the linear contrast stretch RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/lcs_pkg.sv =====
// Package for the linear contrast stretch block: sizes, payload structs and
// the command and status groups between controller and datapath. No dependencies.
package lcs_pkg;

    localparam int MAX_PIXELS = 64;
    localparam int CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int IDX_W = $clog2(MAX_PIXELS);
    localparam int PIX_W = 8;
    localparam int DIV_CYCLES = 4;
    localparam int ITER_W = $clog2(DIV_CYCLES);
    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_in;
        logic             frame_end;
    } lcs_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             run_last;
        logic             overflow;
    } lcs_out_t;

    typedef struct packed {
        logic load_open;
        logic store;
        logic rd;
        logic div_start;
        logic div_step;
        logic put;
        logic next_idx;
        logic clear;
    } lcs_cmd_t;

    typedef struct packed {
        logic div_last;
        logic last_idx;
        logic out_free;
    } lcs_sts_t;

endpackage

// ===== design/lcs_ctrl.sv =====
// Controller state machine of the linear contrast stretch block.
// Depends on lcs_pkg for the command and status structs.
module lcs_ctrl
    import lcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pix_valid,
    input  logic     frame_end,
    input  lcs_sts_t sts,
    output lcs_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_READ,
        S_START,
        S_DIV,
        S_PUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_LOAD:
            begin
                cmd.load_open = 1'b1;
                if (pix_valid)
                begin
                    cmd.store = 1'b1;
                    if (frame_end)
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd = 1'b1;
                state_next = S_START;
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.put = 1'b1;
                    if (sts.last_idx)
                    begin
                        cmd.clear = 1'b1;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.next_idx = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/lcs_dp.sv =====
// Datapath of the linear contrast stretch block: frame buffer, min and max
// tracking, a radix-4 restoring divider and the output register. Uses lcs_pkg.
module lcs_dp
    import lcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  lcs_cmd_t cmd,
    input  lcs_in_t  pix_data,
    input  logic     res_stall,
    output lcs_sts_t sts,
    output logic     res_valid,
    output lcs_out_t res_data
);

    logic [PIX_W-1:0] frame_mem [MAX_PIXELS];

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [PIX_W-1:0]  min_reg;
    logic [PIX_W-1:0]  min_next;
    logic [PIX_W-1:0]  max_reg;
    logic [PIX_W-1:0]  max_next;
    logic              dropped_reg;
    logic              dropped_next;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;
    logic [ITER_W-1:0] iter_reg;
    logic [ITER_W-1:0] iter_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    logic [PIX_W-1:0]   rd_data_reg;
    logic [PIX_W-1:0]   rem_reg;
    logic [PIX_W-1:0]   quo_reg;
    logic [PIX_W-1:0]   div_reg;
    logic               zero_reg;
    lcs_out_t           out_data_reg;

    logic               full;
    logic [PIX_W-1:0]   diff;
    logic [2*PIX_W-1:0] num;
    logic [PIX_W:0]     step_a;
    logic [PIX_W:0]     step_b;

    // One restoring division step: shift in a bit, subtract when it fits.
    function automatic logic [PIX_W:0] div_step(input logic [PIX_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [PIX_W-1:0] den);
        logic [PIX_W:0] trial;
        logic [PIX_W:0] diff9;
        trial = {rem, bit_in};
        diff9 = trial - {1'b0, den};
        if (trial >= {1'b0, den})
        begin
            return {1'b1, diff9[PIX_W-1:0]};
        end
        return {1'b0, trial[PIX_W-1:0]};
    endfunction

    assign full = (count_reg == CNT_W'(MAX_PIXELS));
    assign diff = rd_data_reg - min_reg;
    assign num  = {diff, {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff};

    assign step_a = div_step(rem_reg, quo_reg[PIX_W-1], div_reg);
    assign step_b = div_step(step_a[PIX_W-1:0], quo_reg[PIX_W-2], div_reg);

    assign sts.div_last = (iter_reg == ITER_W'(DIV_CYCLES - 1));
    assign sts.last_idx = (({1'b0, rd_idx_reg} + CNT_W'(1)) == count_reg);
    assign sts.out_free = !out_valid_reg || !res_stall;

    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_comb
    begin
        count_next     = count_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        dropped_next   = dropped_reg;
        rd_idx_next    = rd_idx_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg;

        if (cmd.store)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
                if (pix_data.pixel_in < min_reg)
                begin
                    min_next = pix_data.pixel_in;
                end
                if (pix_data.pixel_in > max_reg)
                begin
                    max_next = pix_data.pixel_in;
                end
            end
        end

        if (cmd.div_start)
        begin
            iter_next = '0;
        end
        else if (cmd.div_step)
        begin
            iter_next = iter_reg + ITER_W'(1);
        end

        if (cmd.next_idx)
        begin
            rd_idx_next = rd_idx_reg + IDX_W'(1);
        end

        if (cmd.put)
        begin
            out_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.clear)
        begin
            count_next   = '0;
            min_next     = PIX_MAX;
            max_next     = '0;
            dropped_next = 1'b0;
            rd_idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= PIX_MAX;
            max_reg       <= '0;
            dropped_reg   <= 1'b0;
            rd_idx_reg    <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            dropped_reg   <= dropped_next;
            rd_idx_reg    <= rd_idx_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store && !full)
        begin
            frame_mem[count_reg[IDX_W-1:0]] <= pix_data.pixel_in;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= frame_mem[rd_idx_reg];
        end
    end

    // The quotient is below 256, so the upper numerator byte is already below
    // the divisor and seeds the remainder.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= num[2*PIX_W-1:PIX_W];
            quo_reg  <= num[PIX_W-1:0];
            div_reg  <= max_reg - min_reg;
            zero_reg <= (max_reg == min_reg);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= step_b[PIX_W-1:0];
            quo_reg <= {quo_reg[PIX_W-3:0], step_a[PIX_W], step_b[PIX_W]};
        end
        if (cmd.put)
        begin
            out_data_reg.pixel_out <= zero_reg ? '0 : quo_reg;
            out_data_reg.run_last  <= sts.last_idx;
            out_data_reg.overflow  <= dropped_reg;
        end
    end

endmodule

// ===== design/linear_contrast_stretch.sv =====
// Top level of the linear contrast stretch block.
// Instantiates lcs_ctrl and lcs_dp; uses lcs_pkg and assert_macros.svh.
//
// Pixels of one frame are taken one per cycle and stored in a 64-entry
// buffer while the minimum and maximum are tracked; pixels beyond the buffer
// are dropped and flag overflow on every result of that frame. The request
// marked frame_end starts the output run: each stored pixel is read back and
// divided by the frame's range in a divider that retires two quotient bits
// per cycle. Each result passes through read, setup, the divide steps and the
// output load, and waits while the output is stalled. Input requests are
// stalled during the run and accepted again in the cycle after the final
// result, marked run_last, enters the output register.
`include "assert_macros.svh"

module linear_contrast_stretch
    import lcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pix_valid,
    output logic     pix_stall,
    input  lcs_in_t  pix_data,
    output logic     res_valid,
    input  logic     res_stall,
    output lcs_out_t res_data
);

    lcs_cmd_t cmd;
    lcs_sts_t sts;

    assign pix_stall = !cmd.load_open;

    lcs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .frame_end (pix_data.frame_end),
        .sts       (sts),
        .cmd       (cmd)
    );

    lcs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pix_data  (pix_data),
        .res_stall (res_stall),
        .sts       (sts),
        .res_valid (res_valid),
        .res_data  (res_data)
    );

    `ASSERT_IMPLIES(put_needs_room, clk, rst_n, cmd.put, sts.out_free)
    `ASSERT_IMPLIES(div_after_read, clk, rst_n, cmd.div_start, $past(cmd.rd))
    `ASSERT_NEXT(reopen_after_run, clk, rst_n, cmd.put && sts.last_idx, !pix_stall)

endmodule

// ===== bench/lcs_stretch_checker.sv =====
`timescale 1ns / 100ps
// Checker for the linear contrast stretch block: watches the pixel and result
// channels, predicts every stretched level and compares it with the block.
// Uses lcs_pkg; instantiated by linear_contrast_stretch_test.
module lcs_stretch_checker
    import lcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    input  logic        pix_stall,
    input  lcs_in_t     pix_data,
    input  logic        res_valid,
    input  logic        res_stall,
    input  lcs_out_t    res_data,
    output int unsigned mismatch_count,
    output int unsigned results_owed
);

    localparam int unsigned REPORT_LIMIT = 10;

    logic [PIX_W-1:0] frame_pix [MAX_PIXELS];
    int unsigned      frame_count;
    logic [PIX_W-1:0] frame_lo;
    logic [PIX_W-1:0] frame_hi;
    logic             frame_dropped;
    lcs_out_t         stretched_due [$];

    function automatic logic [PIX_W-1:0] stretch_level(
        input logic [PIX_W-1:0] level,
        input logic [PIX_W-1:0] lo,
        input logic [PIX_W-1:0] hi
    );
        int unsigned clipped;
        int unsigned quotient;
        if (hi <= lo || level < lo)
            return '0;
        clipped = (level > hi) ? 32'(hi) : 32'(level);
        quotient = (32'(PIX_MAX) * (clipped - 32'(lo))) / (32'(hi) - 32'(lo));
        return PIX_W'(quotient);
    endfunction

    task automatic clear_frame();
        frame_count = 0;
        frame_lo = PIX_MAX;
        frame_hi = '0;
        frame_dropped = 1'b0;
    endtask

    task automatic take_pixel(input lcs_in_t req);
        lcs_out_t due;
        if (frame_count < MAX_PIXELS)
        begin
            frame_pix[frame_count] = req.pixel_in;
            frame_count++;
            if (req.pixel_in < frame_lo)
                frame_lo = req.pixel_in;
            if (req.pixel_in > frame_hi)
                frame_hi = req.pixel_in;
        end
        else
        begin
            frame_dropped = 1'b1;
        end
        if (req.frame_end)
        begin
            for (int unsigned k = 0; k < frame_count; k++)
            begin
                due.pixel_out = stretch_level(frame_pix[k], frame_lo, frame_hi);
                due.run_last = (k + 1 == frame_count);
                due.overflow = frame_dropped;
                stretched_due.push_back(due);
            end
            clear_frame();
        end
    endtask

    task automatic check_result(input lcs_out_t got);
        lcs_out_t want;
        if (stretched_due.size() == 0)
        begin
            if (mismatch_count < REPORT_LIMIT)
                $display("%0t: result with none due: pixel_out=%0d run_last=%0b overflow=%0b",
                         $realtime, got.pixel_out, got.run_last, got.overflow);
            mismatch_count++;
        end
        else
        begin
            want = stretched_due.pop_front();
            if (got.pixel_out !== want.pixel_out || got.run_last !== want.run_last
                    || got.overflow !== want.overflow)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display(
                        "%0t: expected pixel_out=%0d run_last=%0b overflow=%0b, got %0d %0b %0b",
                        $realtime, want.pixel_out, want.run_last, want.overflow,
                        got.pixel_out, got.run_last, got.overflow);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            stretched_due.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (pix_valid && !pix_stall)
                take_pixel(pix_data);
            if (res_valid && !res_stall)
                check_result(res_data);
        end
        results_owed = stretched_due.size();
    end

endmodule

// ===== bench/linear_contrast_stretch_test.sv =====
`timescale 1ns / 100ps
// Top of the linear contrast stretch testbench: clock, reset and pixel frames
// with random gaps and output stalls. Needs lcs_pkg, the block and lcs_stretch_checker.
module linear_contrast_stretch_test;
    import lcs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned TAIL_CYCLES = 40;
    localparam int unsigned IDLE_PCT = 38;
    localparam int unsigned RANDOM_FRAMES = 12;

    typedef enum {SHAPE_SPREAD, SHAPE_NARROW, SHAPE_FLAT} frame_shape_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    lcs_in_t     pix_data = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    lcs_out_t    res_data;
    int unsigned mismatch_count;
    int unsigned results_owed;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = IDLE_PCT;
    int unsigned res_stall_pct = IDLE_PCT;
    logic [PIX_W-1:0] frame_pixels [$];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    linear_contrast_stretch u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    lcs_stretch_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pix_data       (pix_data),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .res_data       (res_data),
        .mismatch_count (mismatch_count),
        .results_owed   (results_owed)
    );

    always @(negedge clk)
    begin
        res_stall <= (res_stall_pct != 0) && ($urandom_range(99) < res_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("linear_contrast_stretch test failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [PIX_W-1:0] level, input logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data <= '{pixel_in: level, frame_end: last};
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame();
        foreach (frame_pixels[i])
            send_pixel(frame_pixels[i], i == frame_pixels.size() - 1);
        frame_pixels.delete();
    endtask

    task automatic fill_frame(input int unsigned len);
        frame_shape_t     shape;
        int unsigned      roll;
        int unsigned      level;
        int unsigned      span;
        logic [PIX_W-1:0] base;
        roll = $urandom_range(3);
        shape = (roll < 2) ? SHAPE_SPREAD : ((roll == 2) ? SHAPE_NARROW : SHAPE_FLAT);
        base = PIX_W'($urandom_range(255));
        span = $urandom_range(3);
        repeat (len)
        begin
            case (shape)
                SHAPE_SPREAD: level = $urandom_range(255);
                SHAPE_NARROW: level = 32'(base) + $urandom_range(span);
                default:      level = 32'(base);
            endcase
            if (level > 255)
                level = 255;
            frame_pixels.push_back(PIX_W'(level));
        end
    endtask

    initial
    begin
        int unsigned len;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        frame_pixels = {8'd0, 8'd255, 8'd128, 8'd1, 8'd254};
        send_frame();
        frame_pixels = {8'd7, 8'd7, 8'd7};
        send_frame();
        frame_pixels = {8'd255};
        send_frame();
        frame_pixels = {8'd0};
        send_frame();
        frame_pixels = {8'd100, 8'd101, 8'd100};
        send_frame();
        frame_pixels = {8'd254, 8'd255};
        send_frame();
        frame_pixels = {8'd200, 8'd3, 8'd77, 8'd180, 8'd42};
        send_frame();

        for (int f = 0; f < RANDOM_FRAMES; f++)
        begin
            if (f == 3)
            begin
                pix_valid <= 1'b0;
                while (results_owed != 0)
                    @(negedge clk);
            end
            if (f == 7)
            begin
                send_idle_pct = 0;
                res_stall_pct = 0;
            end
            if (f == 10)
            begin
                send_idle_pct = IDLE_PCT;
                res_stall_pct = IDLE_PCT;
            end
            if (f == 4)
                len = MAX_PIXELS;
            else if (f == 11)
                len = $urandom_range(MAX_PIXELS + 6, MAX_PIXELS + 1);
            else if ($urandom_range(9) == 0)
                len = $urandom_range(30, 13);
            else
                len = $urandom_range(8, 1);
            fill_frame(len);
            send_frame();
        end

        pix_valid <= 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatch_count == 0)
            $display("linear_contrast_stretch test passed");
        else
            $display("linear_contrast_stretch test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/lcs_pkg.sv
design/lcs_ctrl.sv
design/lcs_dp.sv
design/linear_contrast_stretch.sv
bench/lcs_stretch_checker.sv
bench/linear_contrast_stretch_test.sv
